/* src/lrf_pkg.sv */
// lrf_pkg: shared types, constants and command codes for the line rasterizer framebuffer
// used by lrf_stepper, lrf_pixel_writer and line_rasterizer_framebuffer
// no dependencies
package lrf_pkg;

  localparam int SCREEN_WIDTH_DEF = 128;
  localparam int PAGE_COUNT_DEF   = 8;

  localparam int COORD_IN_W = 12;
  // mirrored coordinates reach +2048 and differences reach 4095
  localparam int COORD_W    = 14;
  localparam int D_W        = 16;
  localparam int FUNC_W     = 2;
  localparam int BYTE_W     = 8;

  localparam logic [FUNC_W-1:0] FUNC_DRAW  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ORDER,
    ST_MIRROR,
    ST_INIT,
    ST_STEP,
    ST_DRAIN,
    ST_READ,
    ST_READ_DATA,
    ST_DONE
  } lrf_state_t;

  typedef struct packed {
    logic load;
    logic order;
    logic mirror;
    logic init;
    logic step;
  } lrf_step_ctrl_t;

  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] a;
    logic signed [COORD_W-1:0] b;
    logic                      neg;
    logic                      swp;
  } lrf_pix_t;

endpackage

/* src/line_rasterizer_framebuffer.sv */
// line_rasterizer_framebuffer: monochrome page framebuffer with a bresenham line engine
// usage: one command word in on the input channel, one read_data word out per command.
// func draw sets every on-screen pixel of the line, read returns one column byte
// (zero when page or column is off the store), clear zeroes the store; all other
// commands return zero. Draw, clear and unused codes also return zero.
// draw time is set by the stepper plotting one pixel per cycle along the major axis;
// a read passes through the read and read-data states; clear time is set by the
// single ram write port, which writes every byte of the store.
// one command is in flight at a time: in_stall is high from acceptance until the
// result is loaded into the output register; a result waiting there under out_stall
// holds the next command back only once that command is finished.
// reset: a clearing pass writes zero to all PAGE_COUNT*SCREEN_WIDTH bytes with
// in_stall high, then the block goes idle.
// depends on lrf_pkg, lrf_ram, lrf_stepper, lrf_pixel_writer
module line_rasterizer_framebuffer #(
  parameter int SCREEN_WIDTH = lrf_pkg::SCREEN_WIDTH_DEF,
  parameter int PAGE_COUNT   = lrf_pkg::PAGE_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [lrf_pkg::FUNC_W-1:0]            func,
  input  logic signed [lrf_pkg::COORD_IN_W-1:0] start_x,
  input  logic signed [lrf_pkg::COORD_IN_W-1:0] start_y,
  input  logic signed [lrf_pkg::COORD_IN_W-1:0] end_x,
  input  logic signed [lrf_pkg::COORD_IN_W-1:0] end_y,
  input  logic [2:0]                            read_page,
  input  logic [6:0]                            read_column,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [lrf_pkg::BYTE_W-1:0]            read_data
);
  import lrf_pkg::*;

  localparam int DEPTH  = PAGE_COUNT * SCREEN_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);

  lrf_state_t        state, state_next;
  logic [ADDR_W-1:0] clr_cnt;
  logic              clr_cmd;
  logic [2:0]        rd_page;
  logic [6:0]        rd_col;
  logic [BYTE_W-1:0] res_data;

  logic              accept, clr_last, out_free, rd_ok;
  logic [ADDR_W-1:0] cmd_addr;

  lrf_step_ctrl_t    step_ctrl;
  lrf_pix_t          pix;
  logic              step_last;
  logic              clr_we, rd_cmd_en;

  logic              px_rd_en, px_wr_en, px_busy;
  logic [ADDR_W-1:0] px_rd_addr, px_wr_addr;
  logic [BYTE_W-1:0] px_wr_data;

  logic              ram_wr_en, ram_rd_en;
  logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
  logic [BYTE_W-1:0] ram_wr_data, ram_rd_data;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign clr_last = (clr_cnt == ADDR_W'(DEPTH - 1));
  assign out_free = !out_valid || !out_stall;
  assign cmd_addr = ADDR_W'(rd_page) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(rd_col);
  assign rd_ok    = (32'(rd_page) < 32'(PAGE_COUNT)) && (32'(rd_col) < 32'(SCREEN_WIDTH));

  // sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_last) state_next = clr_cmd ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (func)
            FUNC_DRAW:  state_next = ST_ORDER;
            FUNC_READ:  state_next = ST_READ;
            FUNC_CLEAR: state_next = ST_CLEAR;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_ORDER:     state_next = ST_MIRROR;
      ST_MIRROR:    state_next = ST_INIT;
      ST_INIT:      state_next = ST_STEP;
      ST_STEP: begin
        if (step_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!px_busy) state_next = ST_DONE;
      end
      ST_READ:      state_next = ST_READ_DATA;
      ST_READ_DATA: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // sequencer: control outputs
  always_comb begin
    step_ctrl        = '0;
    step_ctrl.load   = accept && (func == FUNC_DRAW);
    step_ctrl.order  = (state == ST_ORDER);
    step_ctrl.mirror = (state == ST_MIRROR);
    step_ctrl.init   = (state == ST_INIT);
    step_ctrl.step   = (state == ST_STEP);
    clr_we           = (state == ST_CLEAR);
    rd_cmd_en        = (state == ST_READ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      clr_cmd   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        clr_cnt <= '0;
        clr_cmd <= (func == FUNC_CLEAR);
      end else if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      rd_page  <= read_page;
      rd_col   <= read_column;
      res_data <= '0;
    end else if (state == ST_READ_DATA) begin
      res_data <= rd_ok ? ram_rd_data : '0;
    end
    if (state == ST_DONE && out_free) begin
      read_data <= res_data;
    end
  end

  lrf_stepper u_stepper (
    .clk     (clk),
    .ctrl    (step_ctrl),
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .pix     (pix),
    .last    (step_last)
  );

  lrf_pixel_writer #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .PAGE_COUNT   (PAGE_COUNT)
  ) u_writer (
    .clk     (clk),
    .rst     (rst),
    .pix     (pix),
    .rd_en   (px_rd_en),
    .rd_addr (px_rd_addr),
    .rd_data (ram_rd_data),
    .wr_en   (px_wr_en),
    .wr_addr (px_wr_addr),
    .wr_data (px_wr_data),
    .busy    (px_busy)
  );

  assign ram_wr_en   = clr_we | px_wr_en;
  assign ram_wr_addr = clr_we ? clr_cnt : px_wr_addr;
  assign ram_wr_data = clr_we ? '0 : px_wr_data;
  assign ram_rd_en   = rd_cmd_en | px_rd_en;
  assign ram_rd_addr = rd_cmd_en ? cmd_addr : px_rd_addr;

  lrf_ram #(
    .DATA_W (BYTE_W),
    .DEPTH  (DEPTH)
  ) u_frame_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

`ifndef SYNTHESIS
  a_clear_excl: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !px_wr_en)
    else $error("pixel write during clearing pass");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !px_busy)
    else $error("command accepted with pixel pipeline busy");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result word raised outside done state");
`endif

endmodule

/* src/lrf_ram.sv */
// lrf_ram: generic single write port, single read port ram with registered read
// read returns the old contents when the same address is written in that cycle
// no dependencies
module lrf_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/lrf_stepper.sv */
// lrf_stepper: line setup (order, mirror into first octant) and bresenham stepping
// one pixel per cycle in the step phase, driven by the sequencer in the top level
// depends on lrf_pkg
module lrf_stepper (
  input  logic                                      clk,
  input  lrf_pkg::lrf_step_ctrl_t                   ctrl,
  input  logic signed [lrf_pkg::COORD_IN_W-1:0]     start_x,
  input  logic signed [lrf_pkg::COORD_IN_W-1:0]     start_y,
  input  logic signed [lrf_pkg::COORD_IN_W-1:0]     end_x,
  input  logic signed [lrf_pkg::COORD_IN_W-1:0]     end_y,
  output lrf_pkg::lrf_pix_t                         pix,
  output logic                                      last
);
  import lrf_pkg::*;

  logic signed [COORD_W-1:0] x0, y0, x1, y1;
  logic signed [COORD_W-1:0] a, b, a_end, dx, dy;
  logic signed [D_W-1:0]     d, step_e, step_ne;
  logic                      neg, swp;

  logic                      xs, ngt, sw;
  logic signed [COORD_W-1:0] ox0, oy0, ox1, oy1;
  logic signed [COORD_W-1:0] dxr, dyr;

  always_comb begin
    xs  = x0 > x1;
    ox0 = xs ? x1 : x0;
    oy0 = xs ? y1 : y0;
    ox1 = xs ? x0 : x1;
    oy1 = xs ? y0 : y1;
    ngt = oy0 > oy1;
    dxr = x1 - x0;
    dyr = y1 - y0;
    sw  = dyr > dxr;
  end

  assign last = (a == a_end);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x0 <= COORD_W'(start_x);
      y0 <= COORD_W'(start_y);
      x1 <= COORD_W'(end_x);
      y1 <= COORD_W'(end_y);
    end
    if (ctrl.order) begin
      x0  <= ox0;
      x1  <= ox1;
      y0  <= ngt ? -oy0 : oy0;
      y1  <= ngt ? -oy1 : oy1;
      neg <= ngt;
    end
    if (ctrl.mirror) begin
      swp   <= sw;
      a     <= sw ? y0 : x0;
      b     <= sw ? x0 : y0;
      a_end <= sw ? y1 : x1;
      dx    <= sw ? dyr : dxr;
      dy    <= sw ? dxr : dyr;
    end
    if (ctrl.init) begin
      d       <= (D_W'(dy) <<< 1) - D_W'(dx);
      step_e  <= D_W'(dy) <<< 1;
      step_ne <= (D_W'(dy) - D_W'(dx)) <<< 1;
    end
    if (ctrl.step && !last) begin
      a <= a + COORD_W'(1);
      // a tie (d == 0) steps the minor axis
      if (d[D_W-1]) begin
        d <= d + step_e;
      end else begin
        b <= b + COORD_W'(1);
        d <= d + step_ne;
      end
    end
  end

  always_comb begin
    pix.valid = ctrl.step;
    pix.a     = a;
    pix.b     = b;
    pix.neg   = neg;
    pix.swp   = swp;
  end

endmodule

/* src/lrf_pixel_writer.sv */
// lrf_pixel_writer: maps octant pixels back, clips, and sets the bit by read-modify-write
// three stages: map and clip, address and ram read, merge and write with forwarding
// depends on lrf_pkg
module lrf_pixel_writer #(
  parameter int SCREEN_WIDTH = lrf_pkg::SCREEN_WIDTH_DEF,
  parameter int PAGE_COUNT   = lrf_pkg::PAGE_COUNT_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  lrf_pkg::lrf_pix_t                             pix,
  output logic                                          rd_en,
  output logic [$clog2(PAGE_COUNT*SCREEN_WIDTH)-1:0]    rd_addr,
  input  logic [lrf_pkg::BYTE_W-1:0]                    rd_data,
  output logic                                          wr_en,
  output logic [$clog2(PAGE_COUNT*SCREEN_WIDTH)-1:0]    wr_addr,
  output logic [lrf_pkg::BYTE_W-1:0]                    wr_data,
  output logic                                          busy
);
  import lrf_pkg::*;

  localparam int HEIGHT = PAGE_COUNT * 8;
  localparam int DEPTH  = PAGE_COUNT * SCREEN_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int X_W    = $clog2(SCREEN_WIDTH);
  localparam int Y_W    = $clog2(HEIGHT);
  localparam logic signed [COORD_W-1:0] WIDTH_S  = COORD_W'(SCREEN_WIDTH);
  localparam logic signed [COORD_W-1:0] HEIGHT_S = COORD_W'(HEIGHT);

  logic signed [COORD_W-1:0] mx, my;
  logic                      in_scr;

  logic              v1, v2, last_v;
  logic [X_W-1:0]    xr;
  logic [Y_W-1:0]    yr;
  logic [ADDR_W-1:0] addr_c, addr2, last_addr;
  logic [BYTE_W-1:0] mask_c, mask2, last_data, base;

  always_comb begin
    if (pix.neg && pix.swp) begin
      mx = pix.b;
      my = -pix.a;
    end else if (pix.neg) begin
      mx = pix.a;
      my = -pix.b;
    end else if (pix.swp) begin
      mx = pix.b;
      my = pix.a;
    end else begin
      mx = pix.a;
      my = pix.b;
    end
    in_scr = !mx[COORD_W-1] && (mx < WIDTH_S) && !my[COORD_W-1] && (my < HEIGHT_S);
  end

  always_comb begin
    addr_c = ADDR_W'(yr >> 3) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(xr);
    mask_c = 8'h01 << yr[2:0];
  end

  assign rd_en   = v1;
  assign rd_addr = addr_c;

  // the write of the previous pixel is not yet visible to a read issued with it
  assign base    = (last_v && (last_addr == addr2)) ? last_data : rd_data;
  assign wr_en   = v2;
  assign wr_addr = addr2;
  assign wr_data = base | mask2;
  assign busy    = v1 | v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      last_v <= 1'b0;
    end else begin
      v1     <= pix.valid && in_scr;
      v2     <= v1;
      last_v <= v2;
    end
    xr        <= X_W'(mx);
    yr        <= Y_W'(my);
    addr2     <= addr_c;
    mask2     <= mask_c;
    last_addr <= addr2;
    last_data <= wr_data;
  end

endmodule

/* verif/line_rasterizer_framebuffer_tb.sv */
// line_rasterizer_framebuffer_tb: self-checking bench for the line rasterizer framebuffer
// keeps a shadow framebuffer that follows every accepted command and predicts each read word
// depends on lrf_pkg and line_rasterizer_framebuffer
module line_rasterizer_framebuffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrf_pkg::*;

  localparam int SCREEN_W    = SCREEN_WIDTH_DEF;
  localparam int PAGES       = PAGE_COUNT_DEF;
  localparam int SCREEN_H    = PAGES * 8;
  localparam int RANDOM_CMDS = 1875;
  localparam int STALL_LIMIT = 30000;
  localparam int LONG_HOLD   = 300;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]            op;
    logic signed [COORD_IN_W-1:0] x0;
    logic signed [COORD_IN_W-1:0] y0;
    logic signed [COORD_IN_W-1:0] x1;
    logic signed [COORD_IN_W-1:0] y1;
    logic [2:0]                   page;
    logic [6:0]                   col;
    logic                         typed;
    logic [BYTE_W-1:0]            want;
  } cmd_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic [FUNC_W-1:0]            func;
  logic signed [COORD_IN_W-1:0] start_x;
  logic signed [COORD_IN_W-1:0] start_y;
  logic signed [COORD_IN_W-1:0] end_x;
  logic signed [COORD_IN_W-1:0] end_y;
  logic [2:0]                   read_page;
  logic [6:0]                   read_column;
  logic                         out_valid;
  logic                         out_stall;
  logic [BYTE_W-1:0]            read_data;

  logic [BYTE_W-1:0] frame_model [SCREEN_W*PAGES];
  logic [BYTE_W-1:0] expected_bytes [$];
  cmd_t              command_list [$];
  logic [BYTE_W-1:0] oldest_byte;
  int                error_count = 0;
  int                idle_cycles = 0;
  int                words_checked = 0;

  line_rasterizer_framebuffer i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .read_page   (read_page),
    .read_column (read_column),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  // shadow framebuffer
  function automatic void plot_pixel(int x, int y);
    if (x >= 0 && x < SCREEN_W && y >= 0 && y < SCREEN_H) begin
      frame_model[(y >> 3) * SCREEN_W + x][y & 7] = 1'b1;
    end
  endfunction

  function automatic void plot_mirrored(int a, int b, bit flip_y, bit swap_xy);
    if (flip_y && swap_xy) begin
      plot_pixel(b, -a);
    end else if (flip_y) begin
      plot_pixel(a, -b);
    end else if (swap_xy) begin
      plot_pixel(b, a);
    end else begin
      plot_pixel(a, b);
    end
  endfunction

  function automatic void rasterize_line(int x0, int y0, int x1, int y1);
    int t, dx, dy, d, a, b;
    bit flip_y, swap_xy;
    flip_y  = 1'b0;
    swap_xy = 1'b0;
    if (y0 == y1) begin
      if (x0 > x1) begin
        t = x0; x0 = x1; x1 = t;
      end
      for (t = x0; t <= x1; t++) plot_pixel(t, y0);
      return;
    end
    if (x0 == x1) begin
      if (y0 > y1) begin
        t = y0; y0 = y1; y1 = t;
      end
      for (t = y0; t <= y1; t++) plot_pixel(x0, t);
      return;
    end
    // fold into the first octant, then step along the major axis
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    if (y0 > y1) begin
      y0 = -y0;
      y1 = -y1;
      flip_y = 1'b1;
    end
    if (y1 - y0 > x1 - x0) begin
      t = x0; x0 = y0; y0 = t;
      t = x1; x1 = y1; y1 = t;
      swap_xy = 1'b1;
    end
    dx = x1 - x0;
    dy = y1 - y0;
    d  = 2 * dy - dx;
    a  = x0;
    b  = y0;
    plot_mirrored(a, b, flip_y, swap_xy);
    while (a < x1) begin
      a++;
      if (d < 0) begin
        d += 2 * dy;
      end else begin
        b++;
        d += 2 * (dy - dx);
      end
      plot_mirrored(a, b, flip_y, swap_xy);
    end
  endfunction

  function automatic logic [BYTE_W-1:0] apply_command(cmd_t c);
    logic [BYTE_W-1:0] byte_out;
    byte_out = '0;
    case (c.op)
      FUNC_DRAW: begin
        rasterize_line(c.x0, c.y0, c.x1, c.y1);
      end
      FUNC_READ: begin
        if (c.page < PAGES && c.col < SCREEN_W) begin
          byte_out = frame_model[c.page * SCREEN_W + c.col];
        end
      end
      FUNC_CLEAR: begin
        foreach (frame_model[k]) frame_model[k] = '0;
      end
      default: begin
      end
    endcase
    return byte_out;
  endfunction

  function automatic cmd_t make_cmd(logic [FUNC_W-1:0] op, int x0, int y0, int x1, int y1,
                                    int page, int col, bit typed, int want);
    cmd_t c;
    c.op    = op;
    c.x0    = COORD_IN_W'(x0);
    c.y0    = COORD_IN_W'(y0);
    c.x1    = COORD_IN_W'(x1);
    c.y1    = COORD_IN_W'(y1);
    c.page  = 3'(page);
    c.col   = 7'(col);
    c.typed = typed;
    c.want  = BYTE_W'(want);
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick, cx, cy;
    c.op    = FUNC_READ;
    c.x0    = COORD_IN_W'($urandom);
    c.y0    = COORD_IN_W'($urandom);
    c.x1    = COORD_IN_W'($urandom);
    c.y1    = COORD_IN_W'($urandom);
    c.page  = 3'($urandom);
    c.col   = 7'($urandom);
    c.typed = 1'b0;
    c.want  = '0;
    pick = $urandom_range(99);
    cx = int'($urandom_range(SCREEN_W + 15)) - 8;
    cy = int'($urandom_range(SCREEN_H + 15)) - 8;
    if (pick < 40) begin
      // mostly on screen, edges crossed now and then
      c.op = FUNC_DRAW;
      c.x0 = COORD_IN_W'(cx);
      c.y0 = COORD_IN_W'(cy);
      c.x1 = COORD_IN_W'(int'($urandom_range(SCREEN_W + 15)) - 8);
      c.y1 = COORD_IN_W'(int'($urandom_range(SCREEN_H + 15)) - 8);
    end else if (pick < 48) begin
      // short lines, degenerate ones included
      c.op = FUNC_DRAW;
      c.x0 = COORD_IN_W'(cx);
      c.y0 = COORD_IN_W'(cy);
      c.x1 = COORD_IN_W'(cx + int'($urandom_range(8)) - 4);
      c.y1 = COORD_IN_W'(cy + int'($urandom_range(8)) - 4);
    end else if (pick < 54) begin
      c.op = FUNC_DRAW;
      c.x0 = COORD_IN_W'(cx);
      c.y0 = COORD_IN_W'(cy);
      if ($urandom_range(1) == 0) begin
        c.x1 = COORD_IN_W'(int'($urandom_range(SCREEN_W + 15)) - 8);
        c.y1 = c.y0;
      end else begin
        c.x1 = c.x0;
        c.y1 = COORD_IN_W'(int'($urandom_range(SCREEN_H + 15)) - 8);
      end
    end else if (pick < 57) begin
      // full coordinate range, long and slow
      c.op = FUNC_DRAW;
    end else if (pick < 59) begin
      c.op = FUNC_CLEAR;
    end else if (pick < 62) begin
      c.op = FUNC_UNUSED;
    end
    return c;
  endfunction

  task automatic build_commands();
    // read after reset, extremes, spans, a single pixel, clipping, unused code, clear
    command_list.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 1, 8'h00));
    command_list.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 7, 127, 1, 8'h00));
    command_list.push_back(make_cmd(FUNC_DRAW, 0, 0, 127, 0, 0, 0, 1, 8'h00));
    command_list.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 1, 8'h01));
    command_list.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 127, 1, 8'h01));
    command_list.push_back(make_cmd(FUNC_DRAW, 127, 63, 127, 0, 0, 0, 1, 8'h00));
    command_list.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 7, 127, 1, 8'hFF));
    command_list.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 127, 1, 8'hFF));
    command_list.push_back(make_cmd(FUNC_DRAW, 5, 10, 5, 10, 0, 0, 1, 8'h00));
    command_list.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 1, 5, 1, 8'h04));
    command_list.push_back(make_cmd(FUNC_DRAW, -2048, -2048, 2047, 2047, 0, 0, 1, 8'h00));
    command_list.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 3, 0, 0));
    command_list.push_back(make_cmd(FUNC_DRAW, 2047, -2048, -2048, 2047, 0, 0, 1, 8'h00));
    command_list.push_back(make_cmd(FUNC_DRAW, 20, 60, 23, 2, 0, 0, 1, 8'h00));
    command_list.push_back(make_cmd(FUNC_DRAW, 100, 40, 30, 45, 0, 0, 1, 8'h00));
    command_list.push_back(make_cmd(FUNC_DRAW, 60, 0, 50, 63, 0, 0, 1, 8'h00));
    command_list.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 7, 51, 0, 0));
    command_list.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 5, 65, 0, 0));
    command_list.push_back(make_cmd(FUNC_UNUSED, -1, 2047, -2048, 1, 7, 127, 1, 8'h00));
    command_list.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 1, 8'h01));
    command_list.push_back(make_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 1, 8'h00));
    command_list.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 1, 8'h00));
    command_list.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 7, 127, 1, 8'h00));
    command_list.push_back(make_cmd(FUNC_DRAW, -5, 30, 200, 30, 0, 0, 1, 8'h00));
    command_list.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 3, 0, 1, 8'h40));
    command_list.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 3, 127, 1, 8'h40));
    for (int n = 0; n < RANDOM_CMDS; n++) command_list.push_back(random_cmd());
  endtask

  // command sender
  initial begin
    cmd_t c;
    int gap;
    bit burst, pause;
    logic [BYTE_W-1:0] predicted;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    func        <= FUNC_DRAW;
    start_x     <= '0;
    start_y     <= '0;
    end_x       <= '0;
    end_y       <= '0;
    read_page   <= '0;
    read_column <= '0;
    foreach (frame_model[k]) frame_model[k] = '0;
    build_commands();
    burst = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < command_list.size(); i++) begin
      c = command_list[i];
      if (i % 64 == 0) burst = ($urandom_range(3) == 0);
      pause = (i == 800 || i == 1500);
      gap = burst ? 0 : $urandom_range(4);
      if (pause && gap == 0) gap = 1;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        while (pause && expected_bytes.size() != 0) @(posedge clk);
      end
      in_valid    <= 1'b1;
      func        <= c.op;
      start_x     <= c.x0;
      start_y     <= c.y0;
      end_x       <= c.x1;
      end_y       <= c.y1;
      read_page   <= c.page;
      read_column <= c.col;
      do @(posedge clk); while (in_stall);
      predicted = apply_command(c);
      expected_bytes.push_back(c.typed ? c.want : predicted);
    end
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // result receiver: short random stalls, bursts without stalls, one long hold-off
  initial begin
    int hold, taken;
    bit burst, long_done;
    taken     = 0;
    burst     = 1'b0;
    long_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      if (taken % 64 == 0) burst = ($urandom_range(3) == 0);
      hold = burst ? 0 : $urandom_range(4);
      if (!long_done && taken == 400) begin
        hold      = LONG_HOLD;
        long_done = 1'b1;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("read_data word 0x%02h with nothing expected", read_data));
      end else begin
        oldest_byte = expected_bytes.pop_front();
        if (read_data !== oldest_byte) begin
          report_mismatch($sformatf("word %0d read_data 0x%02h, expected 0x%02h",
                                    words_checked, read_data, oldest_byte));
        end
      end
      words_checked++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* files.f */
src/lrf_pkg.sv
src/lrf_ram.sv
src/lrf_stepper.sv
src/lrf_pixel_writer.sv
src/line_rasterizer_framebuffer.sv
verif/line_rasterizer_framebuffer_tb.sv
